[hdl/fat_entry_lookup_with_sector_cache_unit_defines.svh]
// Assertion macros used by the bound checker felsc_chk.
`ifndef FAT_ENTRY_LOOKUP_WITH_SECTOR_CACHE_UNIT_DEFINES_SVH
`define FAT_ENTRY_LOOKUP_WITH_SECTOR_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FELSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define FELSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/felsc_pkg.sv]
`timescale 1ns / 1ps

package felsc_pkg;

  localparam int unsigned SectorBytesDef = 512;

  localparam int unsigned CacheDepth = 1024;
  localparam int unsigned CacheAw    = $clog2(CacheDepth);
  localparam int unsigned CacheBanks = 4;
  localparam int unsigned LaneW      = $clog2(CacheBanks);
  localparam int unsigned BankAw     = CacheAw - LaneW;

  localparam int unsigned ClusterW = 28;
  localparam int unsigned SectorW  = 32;
  localparam int unsigned OffsetW  = ClusterW + 2;
  localparam int unsigned PaddrW   = 4;

  localparam logic [1:0] Fat12 = 2'd0;
  localparam logic [1:0] Fat16 = 2'd1;

  localparam logic [ClusterW-1:0] EocFat12 = 28'h0000FF8;
  localparam logic [ClusterW-1:0] EocFat16 = 28'h000FFF8;
  localparam logic [ClusterW-1:0] EocFat32 = 28'hFFFFFF8;

  typedef enum logic [1:0] {
    StEntry = 2'd0,
    StFetch = 2'd1,
    StFill  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RegFatKind  = 2'd0,
    RegReserved = 2'd1,
    RegHidden   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic               en;
    logic [CacheAw-1:0] addr;
    logic [7:0]         data;
  } cache_wr_t;

  typedef struct packed {
    logic               en;
    logic [CacheAw-1:0] addr;
  } cache_rd_t;

endpackage

[hdl/felsc_cache.sv]
`timescale 1ns / 1ps

// 1 KiB byte cache in four byte-interleaved banks; one read returns the
// four bytes at addr .. addr+3 (wrapping), little-endian.
module felsc_cache (
  input  logic                  clk_i,
  input  felsc_pkg::cache_wr_t  wr_i,
  input  felsc_pkg::cache_rd_t  rd_i,
  output logic [31:0]           rd_word_o
);

  localparam int unsigned Banks     = felsc_pkg::CacheBanks;
  localparam int unsigned LaneW     = felsc_pkg::LaneW;
  localparam int unsigned BankAw    = felsc_pkg::BankAw;
  localparam int unsigned CacheAw   = felsc_pkg::CacheAw;
  localparam int unsigned BankDepth = felsc_pkg::CacheDepth / Banks;

  logic [LaneW-1:0] rot_q;
  logic [7:0]       bank_data [Banks];

  for (genvar b = 0; b < Banks; b++) begin : g_bank
    logic [7:0]        mem [BankDepth];
    logic [7:0]        rdata_q;
    logic [BankAw-1:0] row;
    logic              wrap;

    assign wrap = (LaneW'(b) < rd_i.addr[LaneW-1:0]);
    assign row  = rd_i.addr[CacheAw-1:LaneW] + {{(BankAw-1){1'b0}}, wrap};

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.addr[LaneW-1:0] == LaneW'(b))) begin
        mem[wr_i.addr[CacheAw-1:LaneW]] <= wr_i.data;
      end
      if (rd_i.en) begin
        rdata_q <= mem[row];
      end
    end

    assign bank_data[b] = rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rot_q <= rd_i.addr[LaneW-1:0];
    end
  end

  always_comb begin
    logic [LaneW-1:0] sel;
    sel = '0;
    rd_word_o = '0;
    for (int k = 0; k < Banks; k++) begin
      sel = rot_q + LaneW'(k);
      rd_word_o[k*8 +: 8] = bank_data[sel];
    end
  end

endmodule

[hdl/fat_entry_lookup_with_sector_cache_unit.sv]
`timescale 1ns / 1ps

// FAT next-cluster lookup with a one-sector FAT cache. Takes one item per
// cycle while the output does not stall; each item passes the input register,
// then the banked cache read, then the result register before its result is
// offered; stalls on the output back up through those stages. A lookup gives the
// entry value and end-of-chain/free flags on a cache hit, or the absolute
// sector address and count (two sectors for FAT12) to fetch on a miss. Fill
// items write the fetched bytes at fill_index; the one with fill_last set
// marks the last missed sector as cached. The cache RAM has no reset and no
// clearing pass: only bytes that were filled may be looked up. SectorBytes
// must be a power of two. A write to any of the three configuration registers
// drops the cached sector; write registers only while no item is in flight.
module fat_entry_lookup_with_sector_cache_unit #(
  parameter int unsigned SectorBytes = felsc_pkg::SectorBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [felsc_pkg::PaddrW-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [felsc_pkg::ClusterW-1:0]  cluster_i,
  input  logic [9:0]                      fill_index_i,
  input  logic [7:0]                      fill_byte_i,
  input  logic                            fill_last_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [felsc_pkg::ClusterW-1:0]  entry_value_o,
  output logic                            end_of_chain_o,
  output logic                            free_entry_o,
  output logic [31:0]                     fetch_lba_o,
  output logic [1:0]                      fetch_count_o
);

  localparam int unsigned ClusterW    = felsc_pkg::ClusterW;
  localparam int unsigned SectorW     = felsc_pkg::SectorW;
  localparam int unsigned OffsetW     = felsc_pkg::OffsetW;
  localparam int unsigned CacheAw     = felsc_pkg::CacheAw;
  localparam int unsigned SectorShift = $clog2(SectorBytes);
  localparam logic [CacheAw-1:0] ByteMask = CacheAw'(SectorBytes - 1);

  // ---------------- configuration registers ----------------
  logic [1:0]  fat_kind_q, fat_kind_d;
  logic [15:0] reserved_q, reserved_d;
  logic [31:0] hidden_q, hidden_d;
  logic        cfg_wr, cfg_hit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    fat_kind_d = fat_kind_q;
    reserved_d = reserved_q;
    hidden_d   = hidden_q;
    cfg_hit    = 1'b0;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        felsc_pkg::RegFatKind: begin
          fat_kind_d = pwdata[1:0];
          cfg_hit    = 1'b1;
        end
        felsc_pkg::RegReserved: begin
          reserved_d = pwdata[15:0];
          cfg_hit    = 1'b1;
        end
        felsc_pkg::RegHidden: begin
          hidden_d = pwdata;
          cfg_hit  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      felsc_pkg::RegFatKind:  prdata = {30'd0, fat_kind_q};
      felsc_pkg::RegReserved: prdata = {16'd0, reserved_q};
      felsc_pkg::RegHidden:   prdata = hidden_q;
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_kind_q <= felsc_pkg::Fat12;
      reserved_q <= 16'd1;
      hidden_q   <= '0;
    end else begin
      fat_kind_q <= fat_kind_d;
      reserved_q <= reserved_d;
      hidden_q   <= hidden_d;
    end
  end

  logic is_fat12, is_fat16;
  assign is_fat12 = (fat_kind_q == felsc_pkg::Fat12);
  assign is_fat16 = (fat_kind_q == felsc_pkg::Fat16);

  // ---------------- flow control ----------------
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic s0_en, s1_en, out_en, in_fire, s0_fire, s1_fire;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign s0_en      = !s0_valid_q || s1_en;
  assign in_ready_o = s0_en;
  assign in_fire    = in_valid_i && s0_en;
  assign s0_fire    = s0_valid_q && s1_en;
  assign s1_fire    = s1_valid_q && out_en;

  // ---------------- stage 0: input register ----------------
  logic                s0_req_q;
  logic [ClusterW-1:0] s0_cluster_q;
  logic [CacheAw-1:0]  s0_fidx_q;
  logic [7:0]          s0_fbyte_q;
  logic                s0_flast_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_req_q     <= req_type_i;
      s0_cluster_q <= cluster_i;
      s0_fidx_q    <= fill_index_i;
      s0_fbyte_q   <= fill_byte_i;
      s0_flast_q   <= fill_last_i;
    end
  end

  // ---------------- stage 1: sector decode, hit check, cache access -------
  logic [OffsetW-1:0] offset;
  logic [SectorW-1:0] sector;
  logic [CacheAw-1:0] byte_pos;
  logic               hit;

  logic               cache_valid_q, cache_valid_d;
  logic [SectorW-1:0] cached_q, cached_d;
  logic [SectorW-1:0] pending_q, pending_d;

  felsc_pkg::cache_wr_t cache_wr;
  felsc_pkg::cache_rd_t cache_rd;
  logic [31:0]          cache_word;

  always_comb begin
    priority if (is_fat12) begin
      offset = OffsetW'(s0_cluster_q) + OffsetW'(s0_cluster_q[ClusterW-1:1]);
    end else if (is_fat16) begin
      offset = {1'b0, s0_cluster_q, 1'b0};
    end else begin
      offset = {s0_cluster_q, 2'b00};
    end
  end

  assign sector   = SectorW'(offset >> SectorShift) + SectorW'(reserved_q);
  assign byte_pos = offset[CacheAw-1:0] & ByteMask;
  assign hit      = cache_valid_q && (sector == cached_q);

  always_comb begin
    cache_valid_d = cache_valid_q;
    cached_d      = cached_q;
    pending_d     = pending_q;
    if (s0_fire) begin
      if (s0_req_q) begin
        cache_valid_d = s0_flast_q;
        if (s0_flast_q) begin
          cached_d = pending_q;
        end
      end else if (!hit) begin
        pending_d = sector;
      end
    end
    if (cfg_hit) begin
      cache_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_valid_q <= 1'b0;
      cached_q      <= '0;
      pending_q     <= '0;
    end else begin
      cache_valid_q <= cache_valid_d;
      cached_q      <= cached_d;
      pending_q     <= pending_d;
    end
  end

  assign cache_wr.en   = s0_fire && s0_req_q;
  assign cache_wr.addr = s0_fidx_q;
  assign cache_wr.data = s0_fbyte_q;
  assign cache_rd.en   = s0_fire;
  assign cache_rd.addr = byte_pos;

  felsc_cache u_cache (
    .clk_i     (clk_i),
    .wr_i      (cache_wr),
    .rd_i      (cache_rd),
    .rd_word_o (cache_word)
  );

  felsc_pkg::status_e s1_status_q;
  logic               s1_odd_q;
  logic [SectorW-1:0] s1_sector_q;

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      s1_odd_q    <= s0_cluster_q[0];
      s1_sector_q <= sector;
      if (s0_req_q) begin
        s1_status_q <= felsc_pkg::StFill;
      end else if (hit) begin
        s1_status_q <= felsc_pkg::StEntry;
      end else begin
        s1_status_q <= felsc_pkg::StFetch;
      end
    end
  end

  // ---------------- stage 2: entry extraction, result register ----------
  logic [ClusterW-1:0] entry_val, end_mark;
  logic [ClusterW-1:0] next_d;
  logic                eoc_d, free_d;
  logic [31:0]         lba_d;
  logic [1:0]          count_d;

  always_comb begin
    priority if (is_fat12) begin
      entry_val = s1_odd_q ? ClusterW'(cache_word[15:4]) : ClusterW'(cache_word[11:0]);
      end_mark  = felsc_pkg::EocFat12;
    end else if (is_fat16) begin
      entry_val = ClusterW'(cache_word[15:0]);
      end_mark  = felsc_pkg::EocFat16;
    end else begin
      entry_val = cache_word[ClusterW-1:0];
      end_mark  = felsc_pkg::EocFat32;
    end
  end

  always_comb begin
    next_d  = '0;
    eoc_d   = 1'b0;
    free_d  = 1'b0;
    lba_d   = '0;
    count_d = '0;
    unique case (s1_status_q)
      felsc_pkg::StEntry: begin
        next_d = entry_val;
        eoc_d  = (entry_val >= end_mark);
        free_d = (entry_val == '0);
      end
      felsc_pkg::StFetch: begin
        lba_d   = s1_sector_q + hidden_q;
        count_d = is_fat12 ? 2'd2 : 2'd1;
      end
      felsc_pkg::StFill: ;
      default: ;
    endcase
  end

  logic [1:0]          status_q;
  logic [ClusterW-1:0] next_q;
  logic                eoc_q, free_q;
  logic [31:0]         lba_q;
  logic [1:0]          count_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= s1_status_q;
      next_q   <= next_d;
      eoc_q    <= eoc_d;
      free_q   <= free_d;
      lba_q    <= lba_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_en) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_en) begin
        s1_valid_q <= s0_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entry_value_o  = next_q;
  assign end_of_chain_o = eoc_q;
  assign free_entry_o   = free_q;
  assign fetch_lba_o    = lba_q;
  assign fetch_count_o  = count_q;

endmodule

[hdl/felsc_chk.sv]
`timescale 1ns / 1ps
`include "fat_entry_lookup_with_sector_cache_unit_defines.svh"

module felsc_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [felsc_pkg::PaddrW-1:0]    paddr,
  input logic [31:0]                     pwdata,
  input logic [31:0]                     prdata,
  input logic                            pready,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            req_type_i,
  input logic [felsc_pkg::ClusterW-1:0]  cluster_i,
  input logic [9:0]                      fill_index_i,
  input logic [7:0]                      fill_byte_i,
  input logic                            fill_last_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic [felsc_pkg::ClusterW-1:0]  entry_value_o,
  input logic                            end_of_chain_o,
  input logic                            free_entry_o,
  input logic [31:0]                     fetch_lba_o,
  input logic [1:0]                      fetch_count_o
);

  // input side only backs up when the result register is stuck
  `FELSC_ASSERT_IMP(a_ready_only_on_stall, !in_ready_o, out_valid_o && !out_ready_i, "input stalled while output free")

  `FELSC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(entry_value_o) && $stable(fetch_lba_o) && $stable(fetch_count_o), "stalled result changed")

  `FELSC_ASSERT_IMP(a_fill_result_clean, out_valid_o && status_o == felsc_pkg::StFill, entry_value_o == '0 && fetch_lba_o == '0 && fetch_count_o == '0 && !end_of_chain_o && !free_entry_o, "fill result carries data")

  `FELSC_ASSERT_IMP(a_entry_result, out_valid_o && status_o == felsc_pkg::StEntry, fetch_count_o == '0 && fetch_lba_o == '0 && (free_entry_o == (entry_value_o == '0)), "entry result fields inconsistent")

  `FELSC_ASSERT_NXT(a_reserved_readback, psel && penable && pwrite && pready && paddr[3:2] == felsc_pkg::RegReserved, (paddr != $past(paddr)) || (prdata[15:0] == $past(pwdata[15:0])), "reserved sectors readback mismatch")

endmodule

bind fat_entry_lookup_with_sector_cache_unit felsc_chk u_felsc_chk (.*);

[sim/fat_entry_lookup_checker.sv]
`timescale 1ns / 1ps

module fat_entry_lookup_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [felsc_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  input  logic                           pready,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [felsc_pkg::ClusterW-1:0] cluster_i,
  input  logic [9:0]                     fill_index_i,
  input  logic [7:0]                     fill_byte_i,
  input  logic                           fill_last_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [1:0]                     status_o,
  input  logic [felsc_pkg::ClusterW-1:0] entry_value_o,
  input  logic                           end_of_chain_o,
  input  logic                           free_entry_o,
  input  logic [31:0]                    fetch_lba_o,
  input  logic [1:0]                     fetch_count_o,
  output int                             err_cnt,
  output int                             open_cnt,
  output int                             n_entry,
  output int                             n_fetch,
  output int                             n_fill
);

  localparam int unsigned SectorBytes = felsc_pkg::SectorBytesDef;
  localparam int unsigned ClusterW    = felsc_pkg::ClusterW;
  localparam int unsigned SectorW     = felsc_pkg::SectorW;
  localparam int unsigned OffsetW     = felsc_pkg::OffsetW;
  localparam int unsigned CacheAw     = felsc_pkg::CacheAw;
  localparam int unsigned CacheDepth  = felsc_pkg::CacheDepth;
  localparam int unsigned PaddrW      = felsc_pkg::PaddrW;

  typedef struct packed {
    felsc_pkg::status_e  status;
    logic [ClusterW-1:0] entry_value;
    logic                end_of_chain;
    logic                free_entry;
    logic [31:0]         fetch_lba;
    logic [1:0]          fetch_count;
  } fat_result_t;

  logic [7:0]         fat_bytes [CacheDepth];
  logic [1:0]         kind;
  logic [15:0]        rsv_secs;
  logic [31:0]        hid_secs;
  logic [SectorW-1:0] held_sector;
  logic [SectorW-1:0] asked_sector;
  logic               held_ok;
  fat_result_t        result_q [$];
  fat_result_t        want;
  fat_result_t        got;

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    err_cnt++;
    $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
  endtask

  // Next-cluster lookup or cache fill for the item at the input.
  task automatic lookup_next(output fat_result_t r);
    logic [OffsetW-1:0] ofs;
    logic [SectorW-1:0] sec;
    logic [CacheAw-1:0] p0, p1, p2, p3;
    logic [31:0]        val;
    logic [31:0]        mark;
    r = '0;
    if (req_type_i) begin
      fat_bytes[fill_index_i] = fill_byte_i;
      held_ok = fill_last_i;
      if (fill_last_i) begin
        held_sector = asked_sector;
      end
      r.status = felsc_pkg::StFill;
    end else begin
      case (kind)
        felsc_pkg::Fat12: ofs = OffsetW'(cluster_i) + OffsetW'(cluster_i[ClusterW-1:1]);
        felsc_pkg::Fat16: ofs = {1'b0, cluster_i, 1'b0};
        default:          ofs = {cluster_i, 2'b00};
      endcase
      sec = SectorW'(ofs / SectorBytes) + SectorW'(rsv_secs);
      if (!held_ok || sec != held_sector) begin
        asked_sector  = sec;
        r.status      = felsc_pkg::StFetch;
        r.fetch_lba   = sec + hid_secs;
        r.fetch_count = (kind == felsc_pkg::Fat12) ? 2'd2 : 2'd1;
      end else begin
        p0  = CacheAw'(ofs % SectorBytes);
        p1  = p0 + 1'b1;
        p2  = p0 + 2'd2;
        p3  = p0 + 2'd3;
        val = {16'd0, fat_bytes[p1], fat_bytes[p0]};
        case (kind)
          felsc_pkg::Fat12: begin
            val  = cluster_i[0] ? (val >> 4) : (val & 32'h0000_0FFF);
            mark = 32'(felsc_pkg::EocFat12);
          end
          felsc_pkg::Fat16: mark = 32'(felsc_pkg::EocFat16);
          default: begin
            val  = {fat_bytes[p3], fat_bytes[p2], val[15:0]} & 32'h0FFF_FFFF;
            mark = 32'(felsc_pkg::EocFat32);
          end
        endcase
        r.status       = felsc_pkg::StEntry;
        r.entry_value  = val[ClusterW-1:0];
        r.end_of_chain = (val >= mark);
        r.free_entry   = (val == 32'd0);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind         = felsc_pkg::Fat12;
      rsv_secs     = 16'd1;
      hid_secs     = '0;
      held_sector  = '0;
      asked_sector = '0;
      held_ok      = 1'b0;
      result_q.delete();
      open_cnt     = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[PaddrW-1:2])
            felsc_pkg::RegFatKind: begin
              kind    = pwdata[1:0];
              held_ok = 1'b0;
            end
            felsc_pkg::RegReserved: begin
              rsv_secs = pwdata[15:0];
              held_ok  = 1'b0;
            end
            felsc_pkg::RegHidden: begin
              hid_secs = pwdata;
              held_ok  = 1'b0;
            end
            default: ;
          endcase
        end else begin
          case (paddr[PaddrW-1:2])
            felsc_pkg::RegFatKind: begin
              if (prdata !== {30'd0, kind}) report("fat_kind read", {30'd0, kind}, prdata);
            end
            felsc_pkg::RegReserved: begin
              if (prdata !== {16'd0, rsv_secs}) begin
                report("reserved_sectors read", {16'd0, rsv_secs}, prdata);
              end
            end
            felsc_pkg::RegHidden: begin
              if (prdata !== hid_secs) report("hidden_sectors read", hid_secs, prdata);
            end
            default: ;
          endcase
        end
      end

      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          report("result with none pending, status", '0, 32'(status_o));
        end else begin
          want = result_q.pop_front();
          case (want.status)
            felsc_pkg::StEntry: n_entry++;
            felsc_pkg::StFetch: n_fetch++;
            default:            n_fill++;
          endcase
          if (status_o !== want.status) report("status", 32'(want.status), 32'(status_o));
          if (entry_value_o !== want.entry_value) begin
            report("entry value", 32'(want.entry_value), 32'(entry_value_o));
          end
          if (end_of_chain_o !== want.end_of_chain) begin
            report("end_of_chain", 32'(want.end_of_chain), 32'(end_of_chain_o));
          end
          if (free_entry_o !== want.free_entry) begin
            report("free_entry", 32'(want.free_entry), 32'(free_entry_o));
          end
          if (fetch_lba_o !== want.fetch_lba) report("fetch_lba", want.fetch_lba, fetch_lba_o);
          if (fetch_count_o !== want.fetch_count) begin
            report("fetch_count", 32'(want.fetch_count), 32'(fetch_count_o));
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        lookup_next(got);
        result_q = {result_q, got};
      end
      open_cnt = result_q.size();
    end
  end

endmodule

[sim/tb_fat_entry_lookup_with_sector_cache_unit.sv]
`timescale 1ns / 1ps

module tb_fat_entry_lookup_with_sector_cache_unit;

  localparam int unsigned ClusterW     = felsc_pkg::ClusterW;
  localparam int unsigned PaddrW       = felsc_pkg::PaddrW;
  localparam int unsigned CacheDepth   = felsc_pkg::CacheDepth;
  localparam logic [1:0]  FatKind32    = 2'd2;
  localparam logic [1:0]  FatKindAlias = 2'd3;
  localparam logic [1:0]  RegBeyond    = 2'd3;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned IdlePct      = 7;
  localparam int unsigned NumPhases    = 8;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PaddrW-1:0]   paddr        = '0;
  logic [31:0]         pwdata       = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                req_type_i   = 1'b0;
  logic [ClusterW-1:0] cluster_i    = '0;
  logic [9:0]          fill_index_i = '0;
  logic [7:0]          fill_byte_i  = '0;
  logic                fill_last_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [1:0]          status_o;
  logic [ClusterW-1:0] entry_value_o;
  logic                end_of_chain_o;
  logic                free_entry_o;
  logic [31:0]         fetch_lba_o;
  logic [1:0]          fetch_count_o;

  int err_cnt;
  int open_cnt;
  int n_entry;
  int n_fetch;
  int n_fill;
  int n_sent;
  int n_settings;

  logic                quiet        = 1'b0;
  logic                hold_req     = 1'b0;
  logic [ClusterW-1:0] last_cluster = '0;

  fat_entry_lookup_with_sector_cache_unit i_dut (.*);

  fat_entry_lookup_checker i_chk (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // output side: random stalls plus one long hold-off
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= quiet || ($urandom_range(0, 99) >= IdlePct);
      @(posedge clk_i);
    end
  end

  function automatic logic [7:0] fat_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hF8;
      3:       return 8'hF7;
      4:       return 8'h0F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ClusterW-1:0] any_cluster();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return ClusterW'($urandom_range(0, 4095));
      5, 6, 7:       return ClusterW'($urandom_range(0, 1 << 20));
      8:             return '1;
      default:       return ClusterW'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic rt, input logic [ClusterW-1:0] cl, input logic [9:0] fi,
                           input logic [7:0] fb, input logic fl);
    if (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= rt;
    cluster_i    <= cl;
    fill_index_i <= fi;
    fill_byte_i  <= fb;
    fill_last_i  <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic lookup(input logic [ClusterW-1:0] cl);
    send_item(1'b0, cl, 10'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic fill(input logic [9:0] idx, input logic [7:0] b, input logic last);
    send_item(1'b1, ClusterW'($urandom), idx, b, last);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [1:0] k, input logic [15:0] r, input logic [31:0] h);
    drain();
    reg_access(1'b1, felsc_pkg::RegFatKind, {30'($urandom), k});
    reg_access(1'b1, felsc_pkg::RegReserved, {16'($urandom), r});
    reg_access(1'b1, felsc_pkg::RegHidden, h);
    reg_access(1'b1, RegBeyond, $urandom);
    reg_access(1'b0, felsc_pkg::RegFatKind, '0);
    reg_access(1'b0, felsc_pkg::RegReserved, '0);
    reg_access(1'b0, felsc_pkg::RegHidden, '0);
    n_settings++;
  endtask

  // lookup (usually a miss), fill a few bytes, then walk nearby entries, mostly in the cached sector
  task automatic chain_walk();
    logic [ClusterW-1:0] c;
    c = any_cluster();
    lookup(c);
    repeat ($urandom_range(0, 5)) fill(10'($urandom), fat_byte(), 1'b0);
    fill(10'($urandom), fat_byte(), 1'b1);
    repeat ($urandom_range(1, 6)) begin
      lookup(c);
      c = c + ClusterW'($urandom_range(0, 40));
    end
    last_cluster = c;
  endtask

  task automatic random_phase(input int n_items);
    int first;
    first = n_sent;
    while (n_sent - first < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: chain_walk();
        6, 7:             lookup(last_cluster + ClusterW'($urandom_range(0, 300)));
        8: begin
          repeat ($urandom_range(1, 3)) fill(10'($urandom), fat_byte(), 1'($urandom));
        end
        default:          lookup(any_cluster());
      endcase
    end
  endtask

  initial begin
    int pat;
    logic [7:0] b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every cache byte once; the last one caches sector 0 with no miss before it
    for (int blk = 0; blk < CacheDepth / 16; blk++) begin
      pat = $urandom_range(0, 4);
      for (int j = 0; j < 16; j++) begin
        case (pat)
          0: b = 8'h00;
          1: b = 8'hFF;
          2: b = (j % 4 == 0) ? 8'hF8 : ((j % 4 == 3) ? 8'h0F : 8'hFF);
          3: b = 8'($urandom);
          default: b = fat_byte();
        endcase
        fill(10'(blk * 16 + j), b, (blk == CacheDepth / 16 - 1) && (j == 15));
      end
    end

    // FAT12 at reset settings: even/odd entries, entry straddling the sector end
    lookup('0);
    fill(10'd0, 8'h00, 1'b0);
    fill(10'd1023, 8'hFF, 1'b1);
    lookup('0);
    lookup(ClusterW'(1));
    lookup(ClusterW'(340));
    lookup(ClusterW'(341));
    lookup('1);

    // FAT16, sector address wraps through hidden sectors
    set_regs(felsc_pkg::Fat16, 16'hFFFF, 32'hFFFF_FFFF);
    lookup('1);
    fill(10'd510, 8'hF8, 1'b0);
    fill(10'd511, 8'hFF, 1'b1);
    lookup('1);
    lookup(ClusterW'(28'h0FF_FF00));

    // unused kind code acts as FAT32, exact end mark
    set_regs(FatKindAlias, 16'd0, 32'd0);
    lookup('0);
    fill(10'd4, 8'hF8, 1'b0);
    fill(10'd5, 8'hFF, 1'b0);
    fill(10'd6, 8'hFF, 1'b0);
    fill(10'd7, 8'h0F, 1'b1);
    lookup(ClusterW'(1));
    lookup('0);
    lookup(ClusterW'(128));

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_regs(felsc_pkg::Fat12, 16'd0, 32'd0);
        1: set_regs(felsc_pkg::Fat16, 16'd32, 32'hFFFF_FFFF);
        2: set_regs(FatKind32, 16'hFFFF, $urandom);
        3: begin
          quiet = 1'b1;
          set_regs(FatKindAlias, 16'($urandom), 32'h8000_0000);
        end
        4: begin
          quiet = 1'b0;
          set_regs(felsc_pkg::Fat12, 16'd1, $urandom);
        end
        5: set_regs(felsc_pkg::Fat16, 16'($urandom), 32'hFFFF_FF00);
        6: set_regs(FatKind32, 16'd0, 32'd0);
        default: set_regs(felsc_pkg::Fat12, 16'hFFFF, $urandom);
      endcase
      if (ph == 5) hold_req = 1'b1;
      random_phase(PhaseItems);
    end

    drain();
    $display("Sent %0d items over %0d register settings, one %0d-cycle output hold-off.",
             n_sent, n_settings, HoldCycles);
    $display("Got %0d entry reads, %0d sector fetch requests and %0d fill acks.",
             n_entry, n_fetch, n_fill);
    if (err_cnt == 0 && open_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/felsc_pkg.sv
hdl/felsc_cache.sv
hdl/fat_entry_lookup_with_sector_cache_unit.sv
hdl/felsc_chk.sv
sim/fat_entry_lookup_checker.sv
sim/tb_fat_entry_lookup_with_sector_cache_unit.sv
